// ===== rtl/core/waveform_spike_detector_unit_macros.svh =====
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef WAVEFORM_SPIKE_DETECTOR_UNIT_MACROS_SVH
`define WAVEFORM_SPIKE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define WSD_CHECK(label, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
        else $error("spike detector check failed");

// Next-cycle implication.
`define WSD_CHECK_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
        else $error("spike detector check failed");

`endif

// ===== rtl/core/wsd_pkg.sv =====
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int SAMPLES_PER_CHANNEL = 48;
    localparam int NUM_CHANNELS        = 256;
    localparam int COUNT_BITS          = 16;

    localparam int CHANNEL_W = 8;
    localparam int SAMPLE_W  = 14;
    localparam int TOTAL_W   = 16;
    localparam int THR_W     = 8;
    localparam int POS_W     = $clog2(SAMPLES_PER_CHANNEL);
    localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W    = SAMPLE_W + 8;
    localparam int PCT_SCALE = 100;

    localparam logic [THR_W-1:0] THR_RESET = 8'd20;

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample_value;
        logic                 event_end;
    } sample_word_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] result_channel;
        logic                 spike_found;
        logic                 first_spike_ever;
        logic [TOTAL_W-1:0]   channel_spike_total;
        logic                 event_done;
        logic [TOTAL_W-1:0]   spike_event_total;
    } result_word_t;

    typedef struct packed {
        logic                 valid;
        logic [CHANNEL_W-1:0] channel;
        logic                 found;
        logic                 event_end;
        count_t               event_total;
    } tally_req_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

endpackage

// ===== rtl/core/wsd_window.sv =====
`timescale 1ns / 1ps

module wsd_window
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [wsd_pkg::THR_W-1:0]    cfg_wdata,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  wsd_pkg::sample_word_t        sample_data,
    input  logic                         tally_busy,
    output wsd_pkg::tally_req_t          req
);

    logic                             s1_valid_reg;
    wsd_pkg::sample_word_t            s1_data_reg;
    logic [wsd_pkg::THR_W-1:0]        thr_reg;
    logic [wsd_pkg::SAMPLE_W-1:0]     older_reg;
    logic [wsd_pkg::SAMPLE_W-1:0]     middle_reg;
    logic [wsd_pkg::POS_W-1:0]        pos_reg;
    logic                             ch_spiked_reg;
    logic                             ev_spiked_reg;
    wsd_pkg::count_t                  ev_count_reg;

    logic [wsd_pkg::SAMPLE_W:0]       sum;
    logic [wsd_pkg::SAMPLE_W-1:0]     avg;
    logic [wsd_pkg::SAMPLE_W-1:0]     diff;
    logic [wsd_pkg::PROD_W-1:0]       lhs;
    logic [wsd_pkg::PROD_W-1:0]       rhs;
    logic                             spike_now;
    logic                             found;
    logic                             last;
    logic                             ev_any;
    logic                             s1_fire;
    wsd_pkg::count_t                  ev_count_next;

    always_comb
    begin
        sum  = {1'b0, older_reg} + {1'b0, s1_data_reg.sample_value};
        avg  = sum[wsd_pkg::SAMPLE_W:1];
        diff = (middle_reg > avg) ? middle_reg - avg : avg - middle_reg;
        lhs  = wsd_pkg::PROD_W'(diff) * wsd_pkg::PROD_W'(wsd_pkg::PCT_SCALE);
        rhs  = wsd_pkg::PROD_W'(thr_reg) * wsd_pkg::PROD_W'(avg);
        spike_now = (pos_reg >= wsd_pkg::POS_W'(2)) && (avg != '0) && (lhs > rhs);
        found  = ((pos_reg != '0) && ch_spiked_reg) || spike_now;
        last   = (pos_reg == wsd_pkg::POS_W'(wsd_pkg::SAMPLES_PER_CHANNEL - 1));
        ev_any = ev_spiked_reg || found;
        ev_count_next = (s1_data_reg.event_end && ev_any) ?
                        wsd_pkg::sat_inc(ev_count_reg) : ev_count_reg;
        s1_fire      = s1_valid_reg && (!last || !tally_busy);
        sample_ready = !s1_valid_reg || s1_fire;
    end

    always_comb
    begin
        req.valid       = s1_valid_reg && last && !tally_busy;
        req.channel     = s1_data_reg.channel;
        req.found       = found;
        req.event_end   = s1_data_reg.event_end;
        req.event_total = ev_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            thr_reg      <= wsd_pkg::THR_RESET;
        end
        else
        begin
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            s1_data_reg <= sample_data;
        end
    end

    // advance the sample window and channel/event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg     <= '0;
            middle_reg    <= '0;
            pos_reg       <= '0;
            ch_spiked_reg <= 1'b0;
            ev_spiked_reg <= 1'b0;
            ev_count_reg  <= '0;
        end
        else if (s1_fire)
        begin
            older_reg  <= middle_reg;
            middle_reg <= s1_data_reg.sample_value;
            if (last)
            begin
                pos_reg       <= '0;
                ch_spiked_reg <= 1'b0;
                ev_spiked_reg <= s1_data_reg.event_end ? 1'b0 : ev_any;
                ev_count_reg  <= ev_count_next;
            end
            else
            begin
                pos_reg       <= pos_reg + wsd_pkg::POS_W'(1);
                ch_spiked_reg <= found;
            end
        end
    end

endmodule

// ===== rtl/core/wsd_tally.sv =====
`timescale 1ns / 1ps

module wsd_tally
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wsd_pkg::tally_req_t     req,
    output logic                    tally_busy,
    output logic                    result_valid,
    input  logic                    result_ready,
    output wsd_pkg::result_word_t   result_data
);

    wsd_pkg::count_t                    count_mem [wsd_pkg::NUM_CHANNELS];
    logic [wsd_pkg::NUM_CHANNELS-1:0]   seen_reg;

    logic                               s2_valid_reg;
    logic [wsd_pkg::CHANNEL_W-1:0]      s2_ch_reg;
    logic [wsd_pkg::CH_IDX_W-1:0]       s2_idx_reg;
    logic                               s2_found_reg;
    logic                               s2_ev_end_reg;
    logic                               s2_in_range_reg;
    wsd_pkg::count_t                    s2_ev_total_reg;
    wsd_pkg::count_t                    rd_count_reg;
    logic                               rd_seen_reg;

    logic                               out_valid_reg;
    wsd_pkg::result_word_t              out_word_reg;

    logic                               in_range;
    logic [wsd_pkg::CH_IDX_W-1:0]       rd_idx;
    wsd_pkg::count_t                    cur_count;
    wsd_pkg::count_t                    new_count;
    logic                               s2_fire;
    logic                               wr_en;
    wsd_pkg::result_word_t              out_word_next;

    always_comb
    begin
        in_range  = int'(req.channel) < wsd_pkg::NUM_CHANNELS;
        rd_idx    = req.channel[wsd_pkg::CH_IDX_W-1:0];
        cur_count = rd_seen_reg ? rd_count_reg : '0;
        new_count = s2_found_reg ? wsd_pkg::sat_inc(cur_count) : cur_count;
        s2_fire   = s2_valid_reg && (!out_valid_reg || result_ready);
        wr_en     = s2_fire && s2_found_reg && s2_in_range_reg;

        out_word_next.result_channel      = s2_ch_reg;
        out_word_next.spike_found         = s2_found_reg;
        out_word_next.first_spike_ever    = s2_in_range_reg && s2_found_reg && !rd_seen_reg;
        out_word_next.channel_spike_total = s2_in_range_reg ?
                                            wsd_pkg::TOTAL_W'(new_count) : '0;
        out_word_next.event_done          = s2_ev_end_reg;
        out_word_next.spike_event_total   = wsd_pkg::TOTAL_W'(s2_ev_total_reg);

        tally_busy   = s2_valid_reg;
        result_valid = out_valid_reg;
        result_data  = out_word_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && in_range)
        begin
            rd_count_reg <= count_mem[rd_idx];
        end
        if (wr_en)
        begin
            count_mem[s2_idx_reg] <= new_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            rd_seen_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid)
            begin
                rd_seen_reg  <= in_range && seen_reg[rd_idx];
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                seen_reg[s2_idx_reg] <= 1'b1;
            end
            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s2_ch_reg       <= req.channel;
            s2_idx_reg      <= rd_idx;
            s2_found_reg    <= req.found;
            s2_ev_end_reg   <= req.event_end;
            s2_in_range_reg <= in_range;
            s2_ev_total_reg <= req.event_total;
        end
        if (s2_fire)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

// ===== rtl/core/waveform_spike_detector_unit.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake                   | payload
// sample    | in        | sample_valid / sample_ready | sample_data (sample_word_t)
// result    | out       | result_valid / result_ready | result_data (result_word_t)
// config    | in        | cfg_we                      | cfg_wdata (threshold percent)
//
// One sample word is accepted per cycle unless a last word waits on a full table
// stage; the spike compare runs in the input stage. A channel's last word passes
// the input stage, the count table read and the output register to its result.
// Reset clears control state and the per-channel valid bits at once; no clearing pass.
// A held result word stalls the table stage; a last word waits while that stage is full.

module waveform_spike_detector_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [wsd_pkg::THR_W-1:0]    cfg_wdata,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  wsd_pkg::sample_word_t        sample_data,
    output logic                         result_valid,
    input  logic                         result_ready,
    output wsd_pkg::result_word_t        result_data
);

`include "waveform_spike_detector_unit_macros.svh"

    wsd_pkg::tally_req_t    req;
    logic                   tally_busy;

    wsd_window u_window
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .tally_busy   (tally_busy),
        .req          (req)
    );

    wsd_tally u_tally
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .tally_busy   (tally_busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    `WSD_CHECK(first_needs_found, result_valid && result_data.first_spike_ever, result_data.spike_found)
    `WSD_CHECK(first_total_one, result_valid && result_data.first_spike_ever, result_data.channel_spike_total == 16'd1)
    `WSD_CHECK(no_issue_when_busy, req.valid, !tally_busy)
    `WSD_CHECK_NEXT(issue_fills_tally, req.valid, tally_busy)

endmodule
